@@ hdl/rgbc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the rgbc colour classifier
// no dependencies; used by the interfaces, the rule evaluator and the top level

package rgbc_pkg;

   // default width of one channel count
   localparam int unsigned DEFAULT_SAMPLE_BITS = 16;

   // width of the colour class field
   localparam int unsigned CLASS_W = 3;

   // width of a ratio coefficient (largest is 125)
   localparam int unsigned COEF_W = 7;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_BLACK  = 3'd0,
      CLASS_WHITE  = 3'd1,
      CLASS_BLUE   = 3'd2,
      CLASS_RED    = 3'd3,
      CLASS_GREEN  = 3'd4,
      CLASS_YELLOW = 3'd5
   } colour_class_type;

endpackage

@@ hdl/rgbc_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample items and class items
// depends on rgbc_pkg

interface rgbc_req_if #(
   parameter int unsigned SAMPLE_BITS = rgbc_pkg::DEFAULT_SAMPLE_BITS
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] red_level;
   logic [SAMPLE_BITS-1:0] green_level;
   logic [SAMPLE_BITS-1:0] blue_level;
   logic [SAMPLE_BITS-1:0] clear_level;

   modport source (output valid, red_level, green_level, blue_level, clear_level,
                   input ready);
   modport sink   (input valid, red_level, green_level, blue_level, clear_level,
                   output ready);
endinterface

interface rgbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rgbc_pkg::CLASS_W-1:0] colour_class;

   modport source (output valid, colour_class, input ready);
   modport sink   (input valid, colour_class, output ready);
endinterface

@@ hdl/rgbc_rule_eval.sv @@
`timescale 1ns / 1ps
// combinational threshold rule chain for one rgbc sample
// depends on rgbc_pkg

module rgbc_rule_eval #(
   parameter int unsigned SAMPLE_BITS = rgbc_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic [SAMPLE_BITS-1:0]     red_level,
   input  logic [SAMPLE_BITS-1:0]     green_level,
   input  logic [SAMPLE_BITS-1:0]     blue_level,
   input  logic [SAMPLE_BITS-1:0]     clear_level,
   output rgbc_pkg::colour_class_type colour_class
);

   // total of three channels, then room for a coefficient up to 127
   localparam int unsigned SUM_W  = SAMPLE_BITS + 2;
   localparam int unsigned PROD_W = SUM_W + rgbc_pkg::COEF_W;
   localparam int unsigned LVL_W  = 32;

   // constant-coefficient multiply, reduces to shifts and adds
   function automatic logic [PROD_W-1:0] scale(input logic [PROD_W-1:0] v,
                                               input logic [rgbc_pkg::COEF_W-1:0] k);
      return v * PROD_W'(k);
   endfunction

   logic [SUM_W-1:0]       total;
   logic [SAMPLE_BITS-1:0] dom;
   logic [SAMPLE_BITS-1:0] least;
   logic [SAMPLE_BITS-1:0] chroma;
   logic [SAMPLE_BITS-1:0] rg_diff;
   logic [PROD_W-1:0]      r_e, g_e, b_e, t_e, d_e, ch_e, rgd_e;
   logic [PROD_W-1:0]      r100, g100, b100, c100, diff100;
   logic [LVL_W-1:0]       r_l, g_l, b_l, c_l, t_l, ch_l;
   logic                   rule_dark, rule_blue_strong, rule_white_bright, rule_yellow;
   logic                   rule_red, rule_green, rule_blue_weak, rule_black_dim;
   logic                   rule_white_vbright;

   always_comb begin
      total = SUM_W'(red_level) + SUM_W'(green_level) + SUM_W'(blue_level);

      dom   = (red_level > green_level) ? red_level : green_level;
      dom   = (dom > blue_level) ? dom : blue_level;
      least = (red_level < green_level) ? red_level : green_level;
      least = (least < blue_level) ? least : blue_level;
      chroma  = dom - least;
      rg_diff = (red_level > green_level) ? red_level - green_level
                                          : green_level - red_level;

      r_e   = PROD_W'(red_level);
      g_e   = PROD_W'(green_level);
      b_e   = PROD_W'(blue_level);
      t_e   = PROD_W'(total);
      d_e   = PROD_W'(dom);
      ch_e  = PROD_W'(chroma);
      rgd_e = PROD_W'(rg_diff);

      r100    = scale(r_e, 7'd100);
      g100    = scale(g_e, 7'd100);
      b100    = scale(b_e, 7'd100);
      c100    = scale(ch_e, 7'd100);
      diff100 = scale(rgd_e, 7'd100);

      // absolute levels compared at a fixed width so narrow samples still work
      r_l  = LVL_W'(red_level);
      g_l  = LVL_W'(green_level);
      b_l  = LVL_W'(blue_level);
      c_l  = LVL_W'(clear_level);
      t_l  = LVL_W'(total);
      ch_l = LVL_W'(chroma);

      rule_dark = (c_l < 32'd5) || (t_l < 32'd10);

      rule_blue_strong = (b_l > 32'd35) && (b100 > scale(t_e, 7'd38)) &&
                         (b100 > scale(r_e, 7'd118)) && (b100 > scale(g_e, 7'd108)) &&
                         (ch_l > 32'd12);

      rule_white_bright = (c_l > 32'd18000) && (t_l > 32'd20000) &&
                          (c100 < scale(d_e, 7'd55)) &&
                          (r100 > scale(t_e, 7'd22)) && (r100 < scale(t_e, 7'd48)) &&
                          (g100 > scale(t_e, 7'd22)) && (g100 < scale(t_e, 7'd44)) &&
                          (b100 > scale(t_e, 7'd14)) && (b100 < scale(t_e, 7'd32));

      rule_yellow = (r_l > 32'd20) && (g_l > 32'd20) && (b100 < scale(t_e, 7'd16)) &&
                    (r100 > scale(t_e, 7'd32)) && (g100 > scale(t_e, 7'd28)) &&
                    (diff100 < scale(t_e, 7'd18));

      rule_red = (r100 > scale(t_e, 7'd46)) && (g100 < scale(t_e, 7'd33)) &&
                 (r100 > scale(g_e, 7'd122)) && (r100 > scale(b_e, 7'd125));

      rule_green = (g100 > scale(t_e, 7'd38)) && (g100 > scale(r_e, 7'd108)) &&
                   (g100 > scale(b_e, 7'd118)) && (b100 < scale(t_e, 7'd34));

      rule_blue_weak = (b_l > 32'd18) && (b100 > scale(t_e, 7'd34)) &&
                       (b100 > scale(r_e, 7'd108)) && (b100 > scale(g_e, 7'd104)) &&
                       (ch_l > 32'd8);

      rule_black_dim = (c_l < 32'd7000) || (t_l < 32'd7000) ||
                       ((c_l < 32'd12000) && (t_l < 32'd12000) &&
                        (c100 < scale(d_e, 7'd55)));

      rule_white_vbright = (c_l > 32'd26000) && (t_l > 32'd28000) &&
                           (c100 < scale(d_e, 7'd50)) &&
                           (b100 > scale(t_e, 7'd16)) && (b100 < scale(t_e, 7'd36)) &&
                           (r100 > scale(t_e, 7'd24)) && (r100 < scale(t_e, 7'd45)) &&
                           (g100 > scale(t_e, 7'd24)) && (g100 < scale(t_e, 7'd45));

      // first matching rule wins
      if (rule_dark) begin
         colour_class = rgbc_pkg::CLASS_BLACK;
      end else if (rule_blue_strong) begin
         colour_class = rgbc_pkg::CLASS_BLUE;
      end else if (rule_white_bright) begin
         colour_class = rgbc_pkg::CLASS_WHITE;
      end else if (rule_yellow) begin
         colour_class = rgbc_pkg::CLASS_YELLOW;
      end else if (rule_red) begin
         colour_class = rgbc_pkg::CLASS_RED;
      end else if (rule_green) begin
         colour_class = rgbc_pkg::CLASS_GREEN;
      end else if (rule_blue_weak) begin
         colour_class = rgbc_pkg::CLASS_BLUE;
      end else if (rule_black_dim) begin
         colour_class = rgbc_pkg::CLASS_BLACK;
      end else if (rule_white_vbright) begin
         colour_class = rgbc_pkg::CLASS_WHITE;
      end else begin
         colour_class = rgbc_pkg::CLASS_BLACK;
      end
   end

endmodule

@@ hdl/rgbc_colour_classifier_unit.sv @@
`timescale 1ns / 1ps
// top level of the rgbc colour classifier: input register, rule chain, result register
// depends on rgbc_pkg, rgbc_if (rgbc_req_if, rgbc_rsp_if) and rgbc_rule_eval

// Classifies one red/green/blue/clear sample item into a colour class
// (black, white, blue, red, green, yellow). The block holds no state between
// items. An accepted sample lands in an input register, the whole rule chain
// is evaluated combinationally from it, and the class is captured in a result
// register, from which it is presented. The block takes one item per clock
// while the result side is ready; back-pressure on the result side only
// stalls input once both registers are full, so a new sample is still taken
// while a finished result waits. SAMPLE_BITS sets the width of each channel
// count (8 to 24); ratio tests are exact integer cross-products.

module rgbc_colour_classifier_unit #(
   parameter int unsigned SAMPLE_BITS = rgbc_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic          clock,
   input  logic          reset,
   rgbc_req_if.sink      req_chan,
   rgbc_rsp_if.source    rsp_chan
);

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_red_ff, s1_green_ff, s1_blue_ff, s1_clear_ff;

   // result stage
   logic                       s2_valid_ff, s2_valid_in;
   rgbc_pkg::colour_class_type s2_class_ff;
   rgbc_pkg::colour_class_type class_in;

   logic req_accept;
   logic s2_free;   // result stage can take an item this cycle
   logic s2_load;   // input stage hands its item over

   assign s2_free    = !s2_valid_ff || rsp_chan.ready;
   assign s2_load    = s1_valid_ff && s2_free;
   assign req_accept = req_chan.valid && req_chan.ready;

   // input stage is free when empty or when it is moving forward
   assign req_chan.ready = !s1_valid_ff || s2_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_red_ff   <= req_chan.red_level;
         s1_green_ff <= req_chan.green_level;
         s1_blue_ff  <= req_chan.blue_level;
         s1_clear_ff <= req_chan.clear_level;
      end
      if (s2_load) begin
         s2_class_ff <= class_in;
      end
   end

   // the full threshold chain sits between the two registers
   rgbc_rule_eval #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rule_eval (
      .red_level    (s1_red_ff),
      .green_level  (s1_green_ff),
      .blue_level   (s1_blue_ff),
      .clear_level  (s1_clear_ff),
      .colour_class (class_in)
   );

   assign rsp_chan.valid        = s2_valid_ff;
   assign rsp_chan.colour_class = s2_class_ff;

   // an accepted item is always held in the input stage next cycle
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item not held in input stage");

   // a handed-over item shows up at the output with the class computed for it
   a_load_result : assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (rsp_chan.valid && (rsp_chan.colour_class == $past(class_in))))
      else $error("result stage lost or corrupted an item");

   // an empty input stage never refuses an item
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("input refused while input stage empty");

   // only defined class codes leave the block
   a_class_range : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.colour_class <= rgbc_pkg::CLASS_YELLOW))
      else $error("undefined colour class presented");

endmodule
